@@ design/page_run_best_fit_allocator_core_macros.svh @@
// assertion macros used by the allocator rtl
`ifndef PAGE_RUN_BEST_FIT_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_RUN_BEST_FIT_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define PRBFA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define PRBFA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/prbfa_pkg.sv @@
// shared types and codes of the best-fit page allocator
`default_nettype none

package prbfa_pkg;

    // fixed field widths of the stream words
    localparam int MODE_W   = 2;
    localparam int LEN_W    = 11;
    localparam int OWNER_W  = 8;
    localparam int START_W  = 10;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 11;

    // page count after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE_OWNER = 2'd2;

    // result codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_ROOM  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_FREE = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [LEN_W-1:0]   run_length;
        logic [OWNER_W-1:0] owner_id;
        logic [START_W-1:0] start_page;
    } prbfa_req_t;

    typedef struct packed {
        logic idle;
        logic done;
    } prbfa_eng_stat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                took;
    } prbfa_res_t;

endpackage

`default_nettype wire

@@ design/page_run_best_fit_allocator_core.sv @@
// top level of the best-fit contiguous page allocator
//
//  channel   direction  tdata / data                        tuser
//  s_*       in         run_length, owner_id, start_page    mode
//  m_*       out        first_page, pages_moved,            status
//                       pages_free, run_owner
//  cfg_*     in         page_count (11 bits)                -
//
// allocate: one page table entry read per cycle until the best run is known (an exact
//   fit ends the walk early), then one write per granted page
// free run: clears the run from start_page to its end; free owner: clears that owner's pages
// the page table ram port (one read and one write per cycle) paces all of these walks
// after reset and after every page_count write a clearing sweep over all PAGES entries runs,
//   s_tready stays low during it; cfg writes are always taken
// a finished result waits in the output register while the next word is accepted
`default_nettype none

`include "page_run_best_fit_allocator_core_macros.svh"

module page_run_best_fit_allocator_core #(
    parameter int PAGES      = 1024,
    parameter int OWNER_BITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input word
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // run_length[10:0], owner_id[18:11], start_page[28:19]
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    // result word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // first_page[9:0], pages_moved[20:10],
                                        // pages_free[31:21], run_owner[39:32]
    output logic      [1:0]  m_tuser,   // status[1:0]
    // page_count write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data
);

    localparam int CNT_W = ($clog2(PAGES + 1) > 11) ? $clog2(PAGES + 1) : 11;

    // effective page count is page_count capped at the table size
    localparam logic [CNT_W-1:0] RESET_LIVE =
        (PAGES < int'(prbfa_pkg::CFG_RESET)) ? CNT_W'(PAGES) : CNT_W'(prbfa_pkg::CFG_RESET);

    logic [CNT_W-1:0]             live_reg, live_next;
    logic [CNT_W-1:0]             free_total_reg, free_total_next;
    logic [31:0]                  no_room_count_reg, no_room_count_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [39:0]                  m_tdata_reg;
    logic [1:0]                   m_tuser_reg;

    prbfa_pkg::prbfa_req_t        eng_req;
    prbfa_pkg::prbfa_eng_stat_t   eng_stat;
    prbfa_pkg::prbfa_res_t        eng_res;
    logic [CNT_W-1:0]             eng_first, eng_moved;
    logic [OWNER_BITS-1:0]        eng_owner;
    logic                         in_fire, cfg_fire, eng_take;
    logic [CNT_W-1:0]             cfg_ext, cfg_live;
    logic [CNT_W:0]               ft_sum;
    logic [CNT_W-1:0]             ft_after;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_tready  = eng_stat.idle;
    assign in_fire   = s_tvalid && s_tready;

    // engine result moves out once the output register is empty or draining
    assign eng_take  = eng_stat.done && (!m_tvalid_reg || m_tready);

    assign eng_req.mode       = s_tuser;
    assign eng_req.run_length = s_tdata[10:0];
    assign eng_req.owner_id   = s_tdata[18:11];
    assign eng_req.start_page = s_tdata[28:19];

    prbfa_engine #(
        .PAGES      (PAGES),
        .OWNER_BITS (OWNER_BITS),
        .CNT_W      (CNT_W)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clr_start (cfg_fire),
        .live      (live_reg),
        .req_valid (in_fire),
        .req       (eng_req),
        .res_take  (eng_take),
        .stat      (eng_stat),
        .res       (eng_res),
        .res_first (eng_first),
        .res_moved (eng_moved),
        .res_owner (eng_owner)
    );

    assign cfg_ext  = CNT_W'(cfg_data);
    assign cfg_live = (cfg_ext < CNT_W'(PAGES)) ? cfg_ext : CNT_W'(PAGES);

    // free count: grant subtracts (floor at zero), frees add (capped at the live count)
    assign ft_sum = {1'b0, free_total_reg} + {1'b0, eng_moved};
    always_comb begin
        if (eng_res.took) begin
            ft_after = (free_total_reg >= eng_moved) ? free_total_reg - eng_moved : '0;
        end else begin
            ft_after = (ft_sum > {1'b0, live_reg}) ? live_reg : ft_sum[CNT_W-1:0];
        end
    end

    always_comb begin
        live_next          = live_reg;
        free_total_next    = free_total_reg;
        no_room_count_next = no_room_count_reg;
        m_tvalid_next      = m_tvalid_reg;
        if (eng_take) begin
            m_tvalid_next   = 1'b1;
            free_total_next = ft_after;
            if (eng_res.status == prbfa_pkg::STAT_NO_ROOM) begin
                no_room_count_next = no_room_count_reg + 32'd1;
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        // heap re-init
        if (cfg_fire) begin
            live_next          = cfg_live;
            free_total_next    = cfg_live;
            no_room_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg          <= RESET_LIVE;
            free_total_reg    <= RESET_LIVE;
            no_room_count_reg <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            live_reg          <= live_next;
            free_total_reg    <= free_total_next;
            no_room_count_reg <= no_room_count_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    // result payload, loaded with the valid flag
    always_ff @(posedge aclk) begin
        if (eng_take) begin
            m_tdata_reg <= {8'(eng_owner), 11'(ft_after), 11'(eng_moved), 10'(eng_first)};
            m_tuser_reg <= eng_res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // free count never exceeds the pages under management
    `PRBFA_ASSERT_IMP(a_free_bounded, 1'b1, (free_total_reg <= live_reg),
        "free page count above live page count")

    // a failed allocate bumps the out-of-memory counter by one unless a cfg write clears it
    `PRBFA_ASSERT_NXT(a_no_room_count,
        (eng_take && eng_res.status == prbfa_pkg::STAT_NO_ROOM && !cfg_valid),
        (no_room_count_reg == $past(no_room_count_reg) + 32'd1),
        "no-room counter did not advance on a failed allocate")

    // an accepted word always leaves the engine busy on the next cycle
    `PRBFA_ASSERT_NXT(a_busy_after_accept, in_fire, !eng_stat.idle,
        "engine idle right after accepting a word")

endmodule

`default_nettype wire

@@ design/prbfa_ram.sv @@
// generic single-clock ram, one write port, one registered read port
`default_nettype none

module prbfa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/prbfa_engine.sv @@
// page table walker: clear, best-fit scan, mark, free run, free owner
`default_nettype none

module prbfa_engine #(
    parameter int PAGES      = 1024,
    parameter int OWNER_BITS = 8,
    parameter int CNT_W      = ($clog2(PAGES + 1) > 11) ? $clog2(PAGES + 1) : 11
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        clr_start,
    input  wire logic [CNT_W-1:0]            live,
    input  wire logic                        req_valid,
    input  wire prbfa_pkg::prbfa_req_t       req,
    input  wire logic                        res_take,
    output prbfa_pkg::prbfa_eng_stat_t       stat,
    output prbfa_pkg::prbfa_res_t            res,
    output logic      [CNT_W-1:0]            res_first,
    output logic      [CNT_W-1:0]            res_moved,
    output logic      [OWNER_BITS-1:0]       res_owner
);

    localparam int PW = $clog2(PAGES);
    localparam int WW = OWNER_BITS + 2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_MARK  = 3'd3;
    localparam logic [2:0] ST_FREE  = 3'd4;
    localparam logic [2:0] ST_OWNER = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      addr_reg, addr_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic                  rd_v_reg, rd_v_next;
    logic                  head_reg, head_next;
    logic                  found_reg, found_next;
    logic [CNT_W-1:0]      len_reg, len_next;
    logic [CNT_W-1:0]      run_at_reg, run_at_next;
    logic [CNT_W-1:0]      run_len_reg, run_len_next;
    logic [CNT_W-1:0]      best_at_reg, best_at_next;
    logic [CNT_W-1:0]      best_len_reg, best_len_next;
    logic [CNT_W-1:0]      end_reg, end_next;
    logic [CNT_W-1:0]      moved_reg, moved_next;
    logic [CNT_W-1:0]      first_reg, first_next;
    logic [OWNER_BITS-1:0] own_reg, own_next;
    logic [OWNER_BITS-1:0] rowner_reg, rowner_next;
    logic [1:0]            status_reg, status_next;
    logic                  took_reg, took_next;

    logic                  ram_we, ram_re;
    logic [PW-1:0]         ram_waddr, ram_raddr;
    logic [WW-1:0]         ram_wdata, ram_rdata;

    logic                  d_taken, d_ends;
    logic [OWNER_BITS-1:0] d_owner;
    logic                  at_last, issue, better, run_closes;
    logic [CNT_W-1:0]      cand_len;
    logic [CNT_W-1:0]      req_len, req_start;

    // entry layout: taken, ends-run, owner
    prbfa_ram #(
        .WIDTH (WW),
        .DEPTH (PAGES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign d_taken    = ram_rdata[WW-1];
    assign d_ends     = ram_rdata[WW-2];
    assign d_owner    = ram_rdata[OWNER_BITS-1:0];
    assign at_last    = (pos_reg == live - CNT_W'(1));
    assign issue      = (addr_reg < live);
    assign cand_len   = d_taken ? run_len_reg : run_len_reg + CNT_W'(1);
    assign run_closes = d_taken || at_last;
    assign better     = (cand_len >= len_reg) && (!found_reg || cand_len < best_len_reg);
    assign req_len    = CNT_W'(req.run_length);
    assign req_start  = CNT_W'(req.start_page);

    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        pos_next      = addr_reg;
        rd_v_next     = 1'b0;
        head_next     = head_reg;
        found_next    = found_reg;
        len_next      = len_reg;
        run_at_next   = run_at_reg;
        run_len_next  = run_len_reg;
        best_at_next  = best_at_reg;
        best_len_next = best_len_reg;
        end_next      = end_reg;
        moved_next    = moved_reg;
        first_next    = first_reg;
        own_next      = own_reg;
        rowner_next   = rowner_reg;
        status_next   = status_reg;
        took_next     = took_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = addr_reg[PW-1:0];
        ram_raddr     = addr_reg[PW-1:0];
        ram_wdata     = '0;

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                addr_next = addr_reg + CNT_W'(1);
                if (addr_reg == CNT_W'(PAGES - 1)) begin
                    state_next = ST_IDLE;
                    addr_next  = '0;
                end
            end
            ST_IDLE: begin
                if (req_valid) begin
                    len_next     = req_len;
                    own_next     = OWNER_BITS'(req.owner_id);
                    moved_next   = '0;
                    first_next   = '0;
                    rowner_next  = '0;
                    status_next  = prbfa_pkg::STAT_OK;
                    took_next    = 1'b0;
                    found_next   = 1'b0;
                    run_at_next  = '0;
                    run_len_next = '0;
                    head_next    = 1'b1;
                    addr_next    = '0;
                    case (req.mode)
                        prbfa_pkg::MODE_ALLOC: begin
                            if (req_len != '0 && req_len <= live) begin
                                state_next = ST_SCAN;
                            end else begin
                                state_next  = ST_DONE;
                                status_next = prbfa_pkg::STAT_NO_ROOM;
                            end
                        end
                        prbfa_pkg::MODE_FREE_RUN: begin
                            if (req_start < live) begin
                                state_next = ST_FREE;
                                addr_next  = req_start;
                            end else begin
                                state_next  = ST_DONE;
                                status_next = prbfa_pkg::STAT_BAD_FREE;
                            end
                        end
                        prbfa_pkg::MODE_FREE_OWNER: begin
                            state_next = (live != '0) ? ST_OWNER : ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                ram_re    = issue;
                rd_v_next = issue;
                if (issue) begin
                    addr_next = addr_reg + CNT_W'(1);
                end
                if (rd_v_reg) begin
                    if (d_taken) begin
                        run_at_next  = pos_reg + CNT_W'(1);
                        run_len_next = '0;
                    end else begin
                        run_len_next = run_len_reg + CNT_W'(1);
                    end
                    if (run_closes && better) begin
                        found_next    = 1'b1;
                        best_len_next = cand_len;
                        best_at_next  = run_at_reg;
                    end
                    // an exact fit cannot be beaten, so the walk stops there
                    if ((run_closes && better && cand_len == len_reg) || at_last) begin
                        if (found_next) begin
                            state_next = ST_MARK;
                            addr_next  = best_at_next;
                            end_next   = best_at_next + len_reg - CNT_W'(1);
                        end else begin
                            state_next  = ST_DONE;
                            status_next = prbfa_pkg::STAT_NO_ROOM;
                        end
                    end
                end
            end
            ST_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, (addr_reg == end_reg), own_reg};
                addr_next = addr_reg + CNT_W'(1);
                if (addr_reg == end_reg) begin
                    state_next = ST_DONE;
                    took_next  = 1'b1;
                    first_next = best_at_reg;
                    moved_next = len_reg;
                end
            end
            ST_FREE: begin
                ram_re    = issue;
                rd_v_next = issue;
                if (issue) begin
                    addr_next = addr_reg + CNT_W'(1);
                end
                if (rd_v_reg) begin
                    head_next = 1'b0;
                    if (head_reg && !d_taken) begin
                        state_next  = ST_DONE;
                        status_next = prbfa_pkg::STAT_BAD_FREE;
                    end else if (d_taken) begin
                        if (head_reg) begin
                            rowner_next = d_owner;
                        end
                        ram_we     = 1'b1;
                        ram_waddr  = pos_reg[PW-1:0];
                        ram_wdata  = {2'b00, d_owner};
                        moved_next = moved_reg + CNT_W'(1);
                        if (d_ends || at_last) begin
                            state_next = ST_DONE;
                        end
                    end else begin
                        // broken run: stop at the first free page
                        state_next = ST_DONE;
                    end
                end
            end
            ST_OWNER: begin
                ram_re    = issue;
                rd_v_next = issue;
                if (issue) begin
                    addr_next = addr_reg + CNT_W'(1);
                end
                if (rd_v_reg) begin
                    if (d_taken && d_owner == own_reg) begin
                        ram_we     = 1'b1;
                        ram_waddr  = pos_reg[PW-1:0];
                        ram_wdata  = {2'b00, d_owner};
                        moved_next = moved_reg + CNT_W'(1);
                    end
                    if (at_last) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // heap re-init restarts the sweep
        if (clr_start) begin
            state_next = ST_CLEAR;
            addr_next  = '0;
            rd_v_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            rd_v_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            rd_v_reg  <= rd_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        head_reg     <= head_next;
        found_reg    <= found_next;
        len_reg      <= len_next;
        run_at_reg   <= run_at_next;
        run_len_reg  <= run_len_next;
        best_at_reg  <= best_at_next;
        best_len_reg <= best_len_next;
        end_reg      <= end_next;
        moved_reg    <= moved_next;
        first_reg    <= first_next;
        own_reg      <= own_next;
        rowner_reg   <= rowner_next;
        status_reg   <= status_next;
        took_reg     <= took_next;
    end

    assign stat.idle     = (state_reg == ST_IDLE);
    assign stat.done     = (state_reg == ST_DONE);
    assign res.status    = status_reg;
    assign res.took      = took_reg;
    assign res_first     = first_reg;
    assign res_moved     = moved_reg;
    assign res_owner     = rowner_reg;

endmodule

`default_nettype wire
